/* rtl/tsi_pkg.sv */
// ----------------------------------------------------------------------------
// Three-way sorted set intersection: shared types and constants
// Transaction payload structs, item kind codes and default list depth.
// ----------------------------------------------------------------------------
`default_nettype none

package tsi_pkg;

  localparam int DEFAULT_LIST_DEPTH = 64;

  localparam logic [1:0] KIND_LOAD_A = 2'd0;
  localparam logic [1:0] KIND_LOAD_B = 2'd1;
  localparam logic [1:0] KIND_LOAD_C = 2'd2;
  localparam logic [1:0] KIND_START  = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] elem_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] common_value;
    logic               is_last;
    logic               is_empty;
    logic               overflowed;
  } out_item_t;

  // Verdict of the shared three-way compare for one merge step.
  typedef struct packed {
    logic all_eq;
    logic adv_a;
    logic adv_b;
    logic adv_c;
  } cmp_res_t;

endpackage

`default_nettype wire

/* rtl/tsi_list_mem.sv */
// ----------------------------------------------------------------------------
// List storage
// One list of signed values: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tsi_list_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic                clk,
  input  wire logic                wr_en,
  input  wire logic [AW-1:0]       wr_addr,
  input  wire logic signed [31:0]  wr_data,
  input  wire logic [AW-1:0]       rd_addr,
  output logic signed [31:0]       rd_data
);

  logic signed [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* rtl/tsi_cmp.sv */
// ----------------------------------------------------------------------------
// Three-way head compare
// Finds whether the three list heads agree and which heads lie below the max.
// ----------------------------------------------------------------------------
`default_nettype none

module tsi_cmp
  import tsi_pkg::*;
(
  input  wire logic signed [31:0] head_a,
  input  wire logic signed [31:0] head_b,
  input  wire logic signed [31:0] head_c,
  output cmp_res_t                verdict
);

  logic signed [31:0] max_ab;
  logic signed [31:0] max_abc;

  always_comb begin
    max_ab  = (head_b > head_a) ? head_b : head_a;
    max_abc = (head_c > max_ab) ? head_c : max_ab;
    verdict.all_eq = (head_a == head_b) && (head_b == head_c);
    verdict.adv_a  = head_a < max_abc;
    verdict.adv_b  = head_b < max_abc;
    verdict.adv_c  = head_c < max_abc;
  end

endmodule

`default_nettype wire

/* rtl/three_way_sorted_set_intersection.sv */
// Loads leave busy low.
// A start runs the merge as a loop of steps, each a memory read, then a compare,
// for at most count_a + count_b + count_c steps, followed by a flush.
// A match is held until the next match or the flush, and its result appears
// in the cycle after that. The receiver cannot stall, so results never back up.
// Reset clears the list counts and the overflow flag; list contents are kept.
// ----------------------------------------------------------------------------
// Three-way sorted set intersection
// Loads three sorted lists, then merges them to emit their common values.
// ----------------------------------------------------------------------------
`default_nettype none

module three_way_sorted_set_intersection
  import tsi_pkg::*;
#(
  parameter int LIST_DEPTH = DEFAULT_LIST_DEPTH
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire in_item_t  item,
  output logic           busy,
  output logic           result_strobe,
  output out_item_t      result
);

  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_CMP   = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  state_t state;

  logic [CW-1:0] count_a, count_b, count_c;
  logic [CW-1:0] ptr_a, ptr_b, ptr_c;
  logic [CW-1:0] ptr_a_next, ptr_b_next, ptr_c_next;
  logic          overflow_flag;

  // One match is held back until it is known whether another follows.
  logic               pend_valid;
  logic signed [31:0] pend_value;

  logic signed [31:0] head_a, head_b, head_c;
  cmp_res_t           verdict;

  logic accept;
  logic load_a, load_b, load_c;
  logic full_a, full_b, full_c;
  logic any_empty;
  logic done_next;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  assign full_a = (count_a == CW'(LIST_DEPTH));
  assign full_b = (count_b == CW'(LIST_DEPTH));
  assign full_c = (count_c == CW'(LIST_DEPTH));

  assign load_a = accept && (item.kind == KIND_LOAD_A) && !full_a;
  assign load_b = accept && (item.kind == KIND_LOAD_B) && !full_b;
  assign load_c = accept && (item.kind == KIND_LOAD_C) && !full_c;

  assign any_empty = (count_a == '0) || (count_b == '0) || (count_c == '0);

  tsi_list_mem #(.DEPTH(LIST_DEPTH), .AW(AW)) u_mem_a (
    .clk     (clk),
    .wr_en   (load_a),
    .wr_addr (count_a[AW-1:0]),
    .wr_data (item.elem_value),
    .rd_addr (ptr_a[AW-1:0]),
    .rd_data (head_a)
  );

  tsi_list_mem #(.DEPTH(LIST_DEPTH), .AW(AW)) u_mem_b (
    .clk     (clk),
    .wr_en   (load_b),
    .wr_addr (count_b[AW-1:0]),
    .wr_data (item.elem_value),
    .rd_addr (ptr_b[AW-1:0]),
    .rd_data (head_b)
  );

  tsi_list_mem #(.DEPTH(LIST_DEPTH), .AW(AW)) u_mem_c (
    .clk     (clk),
    .wr_en   (load_c),
    .wr_addr (count_c[AW-1:0]),
    .wr_data (item.elem_value),
    .rd_addr (ptr_c[AW-1:0]),
    .rd_data (head_c)
  );

  tsi_cmp u_cmp (
    .head_a  (head_a),
    .head_b  (head_b),
    .head_c  (head_c),
    .verdict (verdict)
  );

  always_comb begin
    ptr_a_next = ptr_a + CW'(verdict.all_eq || verdict.adv_a);
    ptr_b_next = ptr_b + CW'(verdict.all_eq || verdict.adv_b);
    ptr_c_next = ptr_c + CW'(verdict.all_eq || verdict.adv_c);
    done_next  = (ptr_a_next == count_a) || (ptr_b_next == count_b) ||
                 (ptr_c_next == count_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count_a       <= '0;
      count_b       <= '0;
      count_c       <= '0;
      ptr_a         <= '0;
      ptr_b         <= '0;
      ptr_c         <= '0;
      overflow_flag <= 1'b0;
      pend_valid    <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          result_strobe <= 1'b0;
          if (load_a) count_a <= count_a + CW'(1);
          if (load_b) count_b <= count_b + CW'(1);
          if (load_c) count_c <= count_c + CW'(1);
          if (accept) begin
            case (item.kind)
              KIND_LOAD_A: if (full_a) overflow_flag <= 1'b1;
              KIND_LOAD_B: if (full_b) overflow_flag <= 1'b1;
              KIND_LOAD_C: if (full_c) overflow_flag <= 1'b1;
              default: begin
                ptr_a <= '0;
                ptr_b <= '0;
                ptr_c <= '0;
                state <= any_empty ? S_FLUSH : S_READ;
              end
            endcase
          end
        end
        S_READ: begin
          result_strobe <= 1'b0;
          state         <= S_CMP;
        end
        S_CMP: begin
          ptr_a <= ptr_a_next;
          ptr_b <= ptr_b_next;
          ptr_c <= ptr_c_next;
          // A new match proves the held one is not the last.
          result_strobe <= verdict.all_eq && pend_valid;
          if (verdict.all_eq) begin
            pend_valid <= 1'b1;
          end
          state <= done_next ? S_FLUSH : S_READ;
        end
        S_FLUSH: begin
          result_strobe <= 1'b1;
          pend_valid    <= 1'b0;
          count_a       <= '0;
          count_b       <= '0;
          count_c       <= '0;
          overflow_flag <= 1'b0;
          state         <= S_IDLE;
        end
        default: begin
          result_strobe <= 1'b0;
          state         <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == S_CMP && verdict.all_eq) begin
      pend_value <= head_a;
      result.common_value <= pend_value;
      result.is_last      <= 1'b0;
      result.is_empty     <= 1'b0;
      result.overflowed   <= overflow_flag;
    end else if (state == S_FLUSH) begin
      result.common_value <= pend_valid ? pend_value : 32'sd0;
      result.is_last      <= 1'b1;
      result.is_empty     <= !pend_valid;
      result.overflowed   <= overflow_flag;
    end
  end

`ifndef NO_ASSERTIONS
  a_cmp_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> (ptr_a < count_a && ptr_b < count_b && ptr_c < count_c))
    else $error("merge step with a pointer at or past its list end");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && result.is_empty) |-> result.is_last)
    else $error("empty result not marked last");

  a_last_after_flush: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && result.is_last) |-> $past(state == S_FLUSH))
    else $error("last result outside of a flush");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH) |=> (state == S_IDLE && count_a == '0 && count_b == '0 &&
                            count_c == '0 && !overflow_flag && !pend_valid))
    else $error("lists not cleared after a start transaction");
`endif

endmodule

`default_nettype wire
